[rtl/assert_macros.svh]
// Assertion macros included by the table core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error("%m failed");
`else
`define ASSERT_CLK(label, clk, rst, prop)
`define ASSERT_NEVER(label, clk, rst, cond)
`endif
`endif

[rtl/sst_pkg.sv]
package sst_pkg;
  localparam int KeyW = 10;
  localparam int PosW = 8;
  localparam int CntW = 9;
  localparam int PayW = 64;
  localparam int Capacity = 256;

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_LOOKUP = 3'd2,
    OP_READ   = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_KEY_RANGE = 3'd4,
    ST_IDX_RANGE = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPARSE,
    S_DENSE,
    S_DECIDE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_DONE
  } state_t;

  // Dense store access requested by the sequencer.
  typedef struct packed {
    logic            rd_en;
    logic [PosW-1:0] rd_addr;
    logic            wr_en;
    logic [PosW-1:0] wr_addr;
    logic [KeyW-1:0] wr_key;
    logic [PayW-1:0] wr_pay;
  } dense_req_t;
endpackage

[rtl/sst_dense_mem.sv]
module sst_dense_mem
  import sst_pkg::*;
(
  input  logic             clk,
  input  dense_req_t       req,
  output logic [KeyW-1:0]  rd_key,
  output logic [PayW-1:0]  rd_pay
);
  logic [KeyW+PayW-1:0] mem [Capacity];

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= {req.wr_key, req.wr_pay};
    end
    if (req.rd_en) begin
      {rd_key, rd_pay} <= mem[req.rd_addr];
    end
  end
endmodule

[rtl/sst_sparse_mem.sv]
module sst_sparse_mem
  import sst_pkg::*;
(
  input  logic            clk,
  input  logic            rd_en,
  input  logic [KeyW-1:0] rd_addr,
  input  logic            wr_en,
  input  logic [KeyW-1:0] wr_addr,
  input  logic [PosW-1:0] wr_data,
  output logic [PosW-1:0] rd_data
);
  logic [PosW-1:0] mem [1 << KeyW];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule

[rtl/sparse_set_table_core.sv]
// Sparse set table: each transfer on s_axis is one operation (insert, remove,
// lookup, read by dense index, clear) and yields exactly one result transfer
// on m_axis. Insert, remove and lookup pass through a sparse memory read, a
// dense memory read, a decision and the result cycle. Read by index skips the
// sparse lookup and the separate dense read step; clear and unknown codes also
// skip the decision. A remove that finds its key then walks every later dense
// entry, moving each one down: a read step, then a write one place lower.
// The block takes one operation at a time. s_axis_tready is high only while no
// operation is open and the result register is empty, so the next operation is
// accepted only after the result has been taken.
module sparse_set_table_core
  import sst_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // operation[2:0], key[12:3], payload_in[76:13], position_in[84:77], zero fill
  input  logic [87:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // status[2:0], present[3], payload_out[67:4], key_out[77:68],
  // position_out[85:78], entry_count[94:86], zero fill
  output logic [95:0]  m_axis_tdata
);
`include "assert_macros.svh"

  state_t state, state_next;
  logic [2:0]      op;
  logic [KeyW-1:0] key;
  logic [PayW-1:0] pay;
  logic [PosW-1:0] idx;
  logic [CntW-1:0] count, count_next;
  logic [PosW-1:0] pos;
  logic [CntW-1:0] walk;
  logic            out_valid;
  logic [95:0]     out_data;
  logic [85:0]     res;

  dense_req_t      dreq;
  logic [KeyW-1:0] d_key;
  logic [PayW-1:0] d_pay;
  logic            sp_rd, sp_wr;
  logic [KeyW-1:0] sp_waddr;
  logic [PosW-1:0] sp_wdata, sp_q;
  logic            found;
  logic            accept;
  logic            more_after_pos;

  sst_dense_mem u_dense (.clk(clk), .req(dreq), .rd_key(d_key), .rd_pay(d_pay));
  sst_sparse_mem u_sparse (
    .clk(clk), .rd_en(sp_rd), .rd_addr(key), .wr_en(sp_wr), .wr_addr(sp_waddr),
    .wr_data(sp_wdata), .rd_data(sp_q)
  );

  assign accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && !out_valid;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = out_data;
  assign found = ({1'b0, pos} < count) && (d_key == key);
  assign more_after_pos = ({1'b0, pos} + 1'b1) < count;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_SPARSE;
        end
      end
      S_SPARSE: begin
        if (op == OP_READ) begin
          state_next = S_DECIDE;
        end else if (op == OP_INSERT || op == OP_REMOVE || op == OP_LOOKUP) begin
          state_next = S_DENSE;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DENSE: state_next = S_DECIDE;
      S_DECIDE: begin
        if (op == OP_REMOVE && found && more_after_pos) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_SHIFT_RD: state_next = S_SHIFT_WR;
      S_SHIFT_WR: begin
        // count is already one lower here, so more entries remain while
        // the next destination is still below it.
        if (walk + 1'b1 < count) begin
          state_next = S_SHIFT_RD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Memory control.
  always_comb begin
    dreq = '0;
    sp_rd = 1'b0;
    sp_wr = 1'b0;
    sp_waddr = key;
    sp_wdata = '0;
    unique case (state)
      S_SPARSE: begin
        sp_rd = 1'b1;
        if (op == OP_READ) begin
          dreq.rd_en = 1'b1;
          dreq.rd_addr = idx;
        end
      end
      S_DENSE: begin
        dreq.rd_en = 1'b1;
        dreq.rd_addr = sp_q;
      end
      S_DECIDE: begin
        if (op == OP_REMOVE && found && more_after_pos) begin
          dreq.rd_en = 1'b1;
          dreq.rd_addr = pos + 8'd1;
        end
      end
      S_SHIFT_WR: begin
        dreq.wr_en = 1'b1;
        dreq.wr_addr = walk[PosW-1:0];
        dreq.wr_key = d_key;
        dreq.wr_pay = d_pay;
        sp_wr = 1'b1;
        sp_waddr = d_key;
        sp_wdata = walk[PosW-1:0];
        if (walk + 1'b1 < count) begin
          dreq.rd_en = 1'b1;
          dreq.rd_addr = PosW'(walk + 2'd2);
        end
      end
      default: begin
      end
    endcase
    if (state == S_DECIDE && op == OP_INSERT && !found && count < CntW'(Capacity)) begin
      dreq.wr_en = 1'b1;
      dreq.wr_addr = count[PosW-1:0];
      dreq.wr_key = key;
      dreq.wr_pay = pay;
      sp_wr = 1'b1;
      sp_wdata = count[PosW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_axis_tdata[2:0];
      key <= s_axis_tdata[12:3];
      pay <= s_axis_tdata[76:13];
      idx <= s_axis_tdata[84:77];
    end
    if (state == S_DENSE) begin
      pos <= sp_q;
    end
    if (state == S_DECIDE) begin
      walk <= {1'b0, pos};
    end
    if (state == S_SHIFT_WR) begin
      walk <= walk + 1'b1;
    end
  end

  // Result fields and count update.
  always_comb begin
    res = '0;
    count_next = count;
    if (state == S_DECIDE) begin
      unique case (op)
        OP_INSERT: begin
          if (found) begin
            res[2:0] = ST_DUPLICATE;
            res[3] = 1'b1;
            res[67:4] = d_pay;
            res[77:68] = key;
            res[85:78] = pos;
          end else if (count >= CntW'(Capacity)) begin
            res[2:0] = ST_FULL;
          end else begin
            res[2:0] = ST_OK;
            res[3] = 1'b1;
            res[67:4] = pay;
            res[77:68] = key;
            res[85:78] = count[PosW-1:0];
            count_next = count + 1'b1;
          end
        end
        OP_REMOVE: begin
          if (found) begin
            res[2:0] = ST_OK;
            res[67:4] = d_pay;
            res[77:68] = key;
            res[85:78] = pos;
            count_next = count - 1'b1;
          end else begin
            res[2:0] = ST_NOT_FOUND;
          end
        end
        OP_LOOKUP: begin
          if (found) begin
            res[2:0] = ST_OK;
            res[3] = 1'b1;
            res[67:4] = d_pay;
            res[77:68] = key;
            res[85:78] = pos;
          end else begin
            res[2:0] = ST_NOT_FOUND;
          end
        end
        OP_READ: begin
          if ({1'b0, idx} < count) begin
            res[2:0] = ST_OK;
            res[3] = 1'b1;
            res[67:4] = d_pay;
            res[77:68] = d_key;
            res[85:78] = idx;
          end else begin
            res[2:0] = ST_IDX_RANGE;
          end
        end
        default: begin
        end
      endcase
    end else if (state == S_SPARSE && op == OP_CLEAR) begin
      count_next = '0;
    end
  end

  // Result register and count.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      if (state == S_DONE) begin
        out_valid <= 1'b1;
      end else if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end
      if (state == S_SPARSE) begin
        out_data <= '0;
      end else if (state == S_DECIDE) begin
        out_data[85:0] <= res;
      end else if (state == S_DONE) begin
        out_data[95:86] <= {1'b0, count};
      end
    end
  end

  `ASSERT_NEVER(a_count_max, clk, rst, count > CntW'(Capacity))
  `ASSERT_NEVER(a_ready_busy, clk, rst, s_axis_tready && state != S_IDLE)
  `ASSERT_CLK(a_done_valid, clk, rst, state == S_DONE |=> out_valid)
  `ASSERT_NEVER(a_walk_range, clk, rst, state == S_SHIFT_WR && walk >= count)
endmodule

[tb/sparse_set_table_core_tb.sv]
module sparse_set_table_core_tb;
  import sst_pkg::*;

  typedef struct packed {
    logic [7:0]  position;
    logic [63:0] payload;
    logic [9:0]  key;
    logic [2:0]  op;
  } table_op_t;

  typedef struct packed {
    logic [8:0]  count;
    logic [7:0]  position;
    logic [9:0]  key;
    logic [63:0] payload;
    logic        present;
    logic [2:0]  status;
  } table_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [87:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;

  sparse_set_table_core dut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Shadow copy of the table.
  logic [9:0]  shadow_keys [Capacity];
  logic [63:0] shadow_pays [Capacity];
  logic [7:0]  shadow_pos [1024];
  int unsigned shadow_count = 0;

  table_op_t     pending_ops [$];
  table_result_t expected_results [$];
  int errors = 0;
  int ops_sent = 0;
  int results_seen = 0;
  int removes_ok = 0;
  int fulls = 0;
  bit stim_done = 0;
  bit quiet_stretch = 0;
  bit hold_off = 0;

  function automatic bit find_entry(input logic [9:0] k, output int unsigned p);
    p = shadow_pos[k];
    return (p < shadow_count) && (shadow_keys[p] == k);
  endfunction

  function automatic table_result_t apply_op(input table_op_t t);
    table_result_t r;
    int unsigned p;
    r = '0;
    case (t.op)
      OP_INSERT: begin
        if (find_entry(t.key, p)) begin
          r.status = ST_DUPLICATE; r.present = 1'b1;
          r.payload = shadow_pays[p]; r.key = t.key; r.position = p[7:0];
        end else if (shadow_count >= Capacity) begin
          r.status = ST_FULL;
        end else begin
          p = shadow_count;
          shadow_keys[p] = t.key;
          shadow_pays[p] = t.payload;
          shadow_pos[t.key] = p[7:0];
          shadow_count++;
          r.status = ST_OK; r.present = 1'b1;
          r.payload = t.payload; r.key = t.key; r.position = p[7:0];
        end
      end
      OP_REMOVE: begin
        if (!find_entry(t.key, p)) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.status = ST_OK; r.payload = shadow_pays[p];
          r.key = t.key; r.position = p[7:0];
          for (int unsigned i = p; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_pays[i] = shadow_pays[i+1];
            shadow_pos[shadow_keys[i]] = i[7:0];
          end
          shadow_count--;
          shadow_pos[t.key] = '0;
        end
      end
      OP_LOOKUP: begin
        if (find_entry(t.key, p)) begin
          r.status = ST_OK; r.present = 1'b1;
          r.payload = shadow_pays[p]; r.key = t.key; r.position = p[7:0];
        end else begin
          r.status = ST_NOT_FOUND;
        end
      end
      OP_READ: begin
        if (t.position >= shadow_count) begin
          r.status = ST_IDX_RANGE;
        end else begin
          r.status = ST_OK; r.present = 1'b1;
          r.payload = shadow_pays[t.position];
          r.key = shadow_keys[t.position]; r.position = t.position;
        end
      end
      OP_CLEAR: shadow_count = 0;
      default: ;
    endcase
    r.count = shadow_count[8:0];
    return r;
  endfunction

  function automatic logic [63:0] rand_payload();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic queue_op(input logic [2:0] op, input logic [9:0] k,
                          input logic [63:0] pay, input logic [7:0] p);
    table_op_t t;
    t.op = op; t.key = k; t.payload = pay; t.position = p;
    pending_ops = {pending_ops, t};
  endtask

  // Driver.
  always @(posedge clk) begin
    if (!rst) begin
      table_result_t exp_r;
      if (s_axis_tvalid && s_axis_tready) begin
        exp_r = apply_op(s_axis_tdata[84:0]);
        expected_results = {expected_results, exp_r};
        ops_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_ops.size() > 0 && (quiet_stretch || $urandom_range(0, 99) >= 17)) begin
          table_op_t t;
          t = pending_ops.pop_front();
          s_axis_tdata <= {3'b000, t.position, t.payload, t.key, t.op};
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        table_result_t got, want;
        got = m_axis_tdata[94:0];
        results_seen++;
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result %h", got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10)
              $display("Result %0d: expected st=%0d pr=%0b pay=%h key=%0d pos=%0d cnt=%0d, got st=%0d pr=%0b pay=%h key=%0d pos=%0d cnt=%0d",
                       results_seen, want.status, want.present, want.payload, want.key,
                       want.position, want.count, got.status, got.present, got.payload,
                       got.key, got.position, got.count);
          end
        end
      end
      m_axis_tready <= !hold_off && (quiet_stretch || $urandom_range(0, 99) >= 17);
    end
  end

  // Watchdog on cycles without any transfer.
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || rst)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    wait (ops_sent > 300);
    hold_off = 1'b1;
    repeat (400) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    logic [9:0] k;
    for (int i = 0; i < 1024; i++) shadow_pos[i] = '0;
    // Directed part: field extremes, every operation, duplicates, misses, bad index.
    queue_op(OP_INSERT, 10'd0, '0, 8'd0);
    queue_op(OP_INSERT, 10'd1023, '1, 8'd255);
    queue_op(OP_INSERT, 10'd0, 64'h5555, 8'd0);
    queue_op(OP_LOOKUP, 10'd1023, '0, 8'd0);
    queue_op(OP_LOOKUP, 10'd512, '0, 8'd0);
    queue_op(OP_READ, 10'd0, '0, 8'd1);
    queue_op(OP_READ, 10'd0, '0, 8'd2);
    queue_op(OP_READ, 10'd0, '0, 8'd255);
    queue_op(OP_INSERT, 10'd341, 64'hAAAA_AAAA_AAAA_AAAA, 8'd170);
    queue_op(OP_REMOVE, 10'd0, '0, 8'd0);
    queue_op(OP_REMOVE, 10'd0, '0, 8'd0);
    queue_op(OP_READ, 10'd0, '0, 8'd0);
    queue_op(OP_LOOKUP, 10'd341, '0, 8'd0);
    queue_op(OP_CLEAR, '1, '1, '1);
    queue_op(OP_LOOKUP, 10'd1023, '0, 8'd0);
    queue_op(3'd5, 10'd7, '1, 8'd1);
    queue_op(3'd7, 10'd7, '1, 8'd1);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    // Fill to capacity, hit full, then drain partly from the front.
    for (int i = 0; i < 258; i++) queue_op(OP_INSERT, 10'(i * 3), rand_payload(), '0);
    for (int i = 0; i < 20; i++) queue_op(OP_REMOVE, 10'(i * 3), '0, '0);
    queue_op(OP_CLEAR, '0, '0, '0);
    // Random part, weighted towards a small key pool so hits are common.
    for (int i = 0; i < 1500; i++) begin
      int w;
      logic [2:0] op;
      w = $urandom_range(0, 99);
      k = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 63));
      if (w < 40) op = OP_INSERT;
      else if (w < 60) op = OP_REMOVE;
      else if (w < 78) op = OP_LOOKUP;
      else if (w < 95) op = OP_READ;
      else if (w < 97) op = OP_CLEAR;
      else op = 3'($urandom_range(5, 7));
      queue_op(op, k, rand_payload(),
               ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 40)));
      if (i == 700) begin
        wait (pending_ops.size() == 0);
        quiet_stretch = 1'b1;
      end
      if (i == 1000) begin
        wait (pending_ops.size() == 0);
        quiet_stretch = 1'b0;
      end
    end
    wait (pending_ops.size() == 0 && !s_axis_tvalid);
    wait (expected_results.size() == 0);
    repeat (600) @(posedge clk);
    $display("Ran %0d operations and checked %0d results, including a full table.",
             ops_sent, results_seen);
    if (errors == 0 && expected_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end
endmodule
